[design/wbps_pkg.sv]
// Package for the wildcard byte pattern scan core.
// Holds shared widths, register indexes, event and config-write types.
// No dependencies.
package wbps_pkg;

    // Pattern window and position counter sizes
    localparam int MAX_PATTERN = 16;
    localparam int COUNT_WIDTH = 32;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int SHIFT_W     = $clog2(MAX_PATTERN);
    localparam int ADDR_W      = 64;
    localparam int REG_W       = 64;
    localparam int MASK_W      = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WILDCARD     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 3'd4;

    // One configuration write as seen by the front and back units
    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [REG_W-1:0]     data;
    } t_cfg_wr;

    // One scan outcome passed from front to back
    typedef struct packed {
        logic                   found;
        logic [COUNT_WIDTH-1:0] offset;
    } t_event;

    // Clamp the programmed length into 1..MAX_PATTERN
    function automatic logic [LEN_W-1:0] len_in_use(input logic [4:0] len);
        logic [LEN_W-1:0] res;
        if (len == 5'd0) begin
            res = LEN_W'(1);
        end else if (32'(len) > MAX_PATTERN) begin
            res = LEN_W'(MAX_PATTERN);
        end else begin
            res = LEN_W'(len);
        end
        return res;
    endfunction

endpackage

[design/wbps_front.sv]
// Front end of the scan: byte window, position count and masked compare.
// Classifies each accepted byte and pushes found / not-found events.
// Depends on wbps_pkg.
module wbps_front
    import wbps_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg_wr      i_cfg,
    input  logic         i_accept,
    input  logic [7:0]   i_byte,
    input  logic         i_last,
    output logic         o_push,
    output t_event       o_event
);

    localparam int WIN_BITS = 8 * MAX_PATTERN;

    logic [REG_W-1:0]       r_pat_lo;
    logic [REG_W-1:0]       r_pat_hi;
    logic [MASK_W-1:0]      r_mask;
    logic [4:0]             r_len;
    logic [7:0]             r_win [MAX_PATTERN];
    logic [COUNT_WIDTH-1:0] r_seen;
    logic                   r_done;

    logic [LEN_W-1:0]       len;
    logic [SHIFT_W-1:0]     shamt;
    logic [WIN_BITS-1:0]    win_next;
    logic [WIN_BITS-1:0]    win_rev;
    logic [WIN_BITS-1:0]    win_align;
    logic [WIN_BITS-1:0]    pattern;
    logic [MAX_PATTERN-1:0] hit;
    logic [COUNT_WIDTH-1:0] n_seen;
    logic                   match;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_mask   <= '0;
            r_len    <= 5'd1;
        end else if (i_cfg.we) begin
            case (i_cfg.index)
                CFG_PATTERN_LOW:  r_pat_lo <= i_cfg.data;
                CFG_PATTERN_HIGH: r_pat_hi <= i_cfg.data;
                CFG_WILDCARD:     r_mask   <= i_cfg.data[MASK_W-1:0];
                CFG_PATTERN_LEN:  r_len    <= i_cfg.data[4:0];
                default: ;
            endcase
        end
    end

    assign len     = len_in_use(r_len);
    assign shamt   = SHIFT_W'(LEN_W'(MAX_PATTERN) - len);
    assign pattern = WIN_BITS'({r_pat_hi, r_pat_lo});

    // Window after the new byte enters, newest at byte 0
    always_comb begin
        win_next[7:0] = i_byte;
        for (int j = 1; j < MAX_PATTERN; j++) begin
            win_next[8*j +: 8] = r_win[j-1];
        end
    end

    // Reverse, then align so byte i lines up with pattern byte i
    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            win_rev[8*k +: 8] = win_next[8*(MAX_PATTERN-1-k) +: 8];
        end
    end

    assign win_align = win_rev >> {shamt, 3'b000};

    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            hit[i] = (LEN_W'(i) >= len) || r_mask[i]
                     || (win_align[8*i +: 8] == pattern[8*i +: 8]);
        end
    end

    assign n_seen = (r_seen != COUNT_MAX) ? r_seen + 1'b1 : r_seen;
    assign match  = (&hit) && (n_seen >= COUNT_WIDTH'(len));

    // Emit an event on a match or on region end without one
    assign o_push         = i_accept && !r_done && (match || i_last);
    assign o_event.found  = match;
    assign o_event.offset = match ? n_seen - COUNT_WIDTH'(len) : '0;

    // Advance window and count until a match, clear at region end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_done <= 1'b0;
            for (int j = 0; j < MAX_PATTERN; j++) begin
                r_win[j] <= '0;
            end
        end else if (i_accept) begin
            if (i_last) begin
                r_seen <= '0;
                r_done <= 1'b0;
                for (int j = 0; j < MAX_PATTERN; j++) begin
                    r_win[j] <= '0;
                end
            end else if (!r_done) begin
                r_seen <= n_seen;
                r_done <= match;
                for (int j = 0; j < MAX_PATTERN; j++) begin
                    r_win[j] <= win_next[8*j +: 8];
                end
            end
        end
    end

    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_last |=> r_seen == '0 && !r_done)
        else $error("region state not cleared after last byte");

    a_one_per_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_event.found |=> r_done || $past(i_last))
        else $error("match did not close the region");

endmodule

[design/wbps_queue.sv]
// Short event queue between the scan front end and the result stage.
// Two entries; push and pop may happen in the same cycle.
// Depends on wbps_pkg.
module wbps_queue
    import wbps_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_event i_event,
    output logic   o_full,
    output logic   o_valid,
    input  logic   i_pop,
    output t_event o_event
);

    t_event             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_event = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Store pushed events
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_event;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("event queue occupancy out of range");

    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full event queue");

endmodule

[design/wbps_back.sv]
// Result stage: turns queued events into output words.
// Adds the base address to the match offset and holds the result word.
// Depends on wbps_pkg.
module wbps_back
    import wbps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg_wr           i_cfg,
    input  logic              i_ev_valid,
    input  t_event            i_event,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_found,
    output logic [ADDR_W-1:0] o_address
);

    logic [ADDR_W-1:0] r_base;
    logic              r_valid;
    logic              r_found;
    logic [ADDR_W-1:0] r_address;

    // Hold the base address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_cfg.we && i_cfg.index == CFG_BASE_ADDRESS) begin
            r_base <= i_cfg.data[ADDR_W-1:0];
        end
    end

    assign o_pop = i_ev_valid && (!r_valid || i_ready);

    // Load the output word when it is free or being taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_found   <= i_event.found;
            r_address <= i_event.found ? r_base + ADDR_W'(i_event.offset) : '0;
        end
    end

    assign o_valid   = r_valid;
    assign o_found   = r_found;
    assign o_address = r_address;

    a_pop_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_valid)
        else $error("popped event not presented");

    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_found |-> r_address == '0)
        else $error("not-found result carries an address");

endmodule

[design/wildcard_byte_pattern_scan_core.sv]
// Wildcard byte pattern scan core: top level.
// Throughput: one byte per cycle while the queue has room; a full queue stalls input.
// The front end compares the whole window combinationally. The edge that accepts a byte
//   writes its event to the queue, and the output register loads it when that is free.
// Reset: synchronous, active low; clears window, count and queue, registers to defaults.
// Depends on wbps_pkg, wbps_front, wbps_queue, wbps_back.
module wildcard_byte_pattern_scan_core
    import wbps_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [REG_W-1:0]     i_cfg_data,
    // Byte stream in
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [7:0]           i_s_axis_tdata,  // [7:0] data_byte
    input  logic                 i_s_axis_tlast,  // last_byte
    // Result out
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [ADDR_W-1:0]    o_m_axis_tdata,  // [63:0] match_address
    output logic                 o_m_axis_tuser   // [0] found
);

    t_cfg_wr cfg;
    t_event  front_event;
    t_event  queue_event;
    logic    push;
    logic    q_full;
    logic    q_valid;
    logic    pop;
    logic    accept;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    assign o_s_axis_tready = !q_full;
    assign accept          = i_s_axis_tvalid && !q_full;

    wbps_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_accept (accept),
        .i_byte   (i_s_axis_tdata),
        .i_last   (i_s_axis_tlast),
        .o_push   (push),
        .o_event  (front_event)
    );

    wbps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_event (front_event),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_event (queue_event)
    );

    wbps_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_ev_valid (q_valid),
        .i_event    (queue_event),
        .o_pop      (pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_found    (o_m_axis_tuser),
        .o_address  (o_m_axis_tdata)
    );

endmodule

[tb/tb.sv]
// Self-checking bench for wildcard_byte_pattern_scan_core: directed table, then random regions.
// Keeps its own model of the scan window and checks every result word on the output stream.
// Depends on wbps_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
    import wbps_pkg::*;

    localparam int          TARGET_WORDS = 1925;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_WAIT   = 4;
    localparam int          END_WAIT     = 8;
    localparam int          SHOW_MAX     = 10;
    localparam int          DIR_N        = 37;

    // Indexes the core does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] addr;
    } t_scan_outcome;

    // Register write, byte checked by the model, quiet byte, or byte with a typed outcome
    typedef enum logic [2:0] {ROW_REG, ROW_BYTE, ROW_QUIET, ROW_HIT, ROW_MISS} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [REG_W-1:0]     value;  // register data, or address of a typed hit
        logic [7:0]           data;
        logic                 last;
    } t_scan_row;

    t_scan_row dir_rows [DIR_N] = '{
        // reset settings: length 1, pattern byte 0x00, base 0
        '{ROW_HIT,   '0, 64'h0, 8'h00, 1'b0},
        '{ROW_QUIET, '0, 64'h0, 8'hFF, 1'b0},
        '{ROW_QUIET, '0, 64'h0, 8'hFF, 1'b1},
        '{ROW_MISS,  '0, 64'h0, 8'hFF, 1'b1},
        '{ROW_QUIET, '0, 64'h0, 8'h80, 1'b0},
        '{ROW_HIT,   '0, 64'h1, 8'h00, 1'b1},
        // length zero, unused wildcard bits, address wraps past all ones
        '{ROW_REG,   CFG_BASE_ADDRESS, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0},
        '{ROW_REG,   CFG_PATTERN_LOW,  64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0},
        '{ROW_REG,   CFG_WILDCARD,     64'hFFFF_FFFF_FFFF_FFFE, 8'h00, 1'b0},
        '{ROW_REG,   CFG_PATTERN_LEN,  64'hFFFF_FFFF_FFFF_FFE0, 8'h00, 1'b0},
        '{ROW_QUIET, '0, 64'h0, 8'h7F, 1'b0},
        '{ROW_HIT,   '0, 64'h0, 8'hFF, 1'b1},
        // length too large, wildcards at both ends, spare indexes ignored
        '{ROW_REG,   CFG_BASE_ADDRESS, 64'h0000_0000_0000_1000, 8'h00, 1'b0},
        '{ROW_REG,   CFG_PATTERN_LOW,  64'h0706_0504_0302_0100, 8'h00, 1'b0},
        '{ROW_REG,   CFG_PATTERN_HIGH, 64'h0F0E_0D0C_0B0A_0908, 8'h00, 1'b0},
        '{ROW_REG,   CFG_WILDCARD,     64'hFFFF_FFFF_FFFF_8001, 8'h00, 1'b0},
        '{ROW_REG,   CFG_PATTERN_LEN,  64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0},
        '{ROW_REG,   CFG_SPARE_LO,     64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0},
        '{ROW_REG,   CFG_SPARE_HI,     64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0},
        '{ROW_BYTE,  '0, 64'h0, 8'hAA, 1'b0},
        '{ROW_BYTE,  '0, 64'h0, 8'h01, 1'b0},
        '{ROW_BYTE,  '0, 64'h0, 8'h02, 1'b0},
        '{ROW_BYTE,  '0, 64'h0, 8'h03, 1'b0},
        '{ROW_BYTE,  '0, 64'h0, 8'h04, 1'b0},
        '{ROW_BYTE,  '0, 64'h0, 8'h05, 1'b0},
        '{ROW_BYTE,  '0, 64'h0, 8'h06, 1'b0},
        '{ROW_BYTE,  '0, 64'h0, 8'h07, 1'b0},
        '{ROW_BYTE,  '0, 64'h0, 8'h08, 1'b0},
        '{ROW_BYTE,  '0, 64'h0, 8'h09, 1'b0},
        '{ROW_BYTE,  '0, 64'h0, 8'h0A, 1'b0},
        '{ROW_BYTE,  '0, 64'h0, 8'h0B, 1'b0},
        '{ROW_BYTE,  '0, 64'h0, 8'h0C, 1'b0},
        '{ROW_BYTE,  '0, 64'h0, 8'h0D, 1'b0},
        '{ROW_BYTE,  '0, 64'h0, 8'h0E, 1'b0},
        '{ROW_HIT,   '0, 64'h1000, 8'h55, 1'b1},
        // region shorter than the pattern
        '{ROW_BYTE,  '0, 64'h0, 8'h00, 1'b0},
        '{ROW_MISS,  '0, 64'h0, 8'h01, 1'b1}
    };

    // DUT connections
    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = '0;
    logic [REG_W-1:0]     cfg_data = '0;
    logic                 s_valid  = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_data   = '0;
    logic                 s_last   = 1'b0;
    logic                 m_valid;
    logic                 m_ready  = 1'b0;
    logic [ADDR_W-1:0]    m_data;
    logic                 m_user;

    // Shadow registers and scan state of the model
    logic [ADDR_W-1:0]      base_r = '0;
    logic [REG_W-1:0]       pat_lo = '0;
    logic [REG_W-1:0]       pat_hi = '0;
    logic [MASK_W-1:0]      wmask  = '0;
    logic [4:0]             plen   = 5'd1;
    logic [7:0]             win [MAX_PATTERN];
    logic [COUNT_WIDTH-1:0] seen;
    logic                   matched;

    t_scan_outcome due_outcomes [$];
    int            items_sent = 0;
    int            fail_count = 0;
    int            mismatches = 0;
    logic          calm       = 1'b0;
    int unsigned   cycles     = 0;

    wildcard_byte_pattern_scan_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    always #1 clk = ~clk;

    // Abort a hung run
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int len_used();
        if (plen == 5'd0) return 1;
        if (plen > MAX_PATTERN) return MAX_PATTERN;
        return int'(plen);
    endfunction

    function automatic logic [7:0] pattern_at(input int k);
        return (k < 8) ? pat_lo[8*k +: 8] : pat_hi[8*(k-8) +: 8];
    endfunction

    function automatic void clear_region();
        foreach (win[k]) win[k] = 8'h00;
        seen    = '0;
        matched = 1'b0;
    endfunction

    // Shift one byte into the window and work out the outcome it causes
    function automatic void window_scan(input logic [7:0] b, input logic last_b,
                                        output logic hit, output t_scan_outcome res);
        int   n;
        logic ok;
        hit = 1'b0;
        res = '0;
        if (!matched) begin
            n = len_used();
            for (int k = MAX_PATTERN - 1; k > 0; k--) win[k] = win[k-1];
            win[0] = b;
            if (seen != COUNT_MAX) seen = seen + 1'b1;
            ok = (seen >= COUNT_WIDTH'(n));
            for (int k = 0; k < n; k++) begin
                if (!wmask[k] && win[n-1-k] != pattern_at(k)) ok = 1'b0;
            end
            if (ok) begin
                matched   = 1'b1;
                hit       = 1'b1;
                res.found = 1'b1;
                res.addr  = base_r + ADDR_W'(seen - COUNT_WIDTH'(n));
            end else if (last_b) begin
                hit = 1'b1;
            end
        end
        if (last_b) clear_region();
    endfunction

    // Called at a rising edge; returns at the edge that wrote the register
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] v);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_BASE_ADDRESS: base_r = v;
            CFG_PATTERN_LOW:  pat_lo = v;
            CFG_PATTERN_HIGH: pat_hi = v;
            CFG_WILDCARD:     wmask  = v[MASK_W-1:0];
            CFG_PATTERN_LEN:  plen   = v[4:0];
            default: ;
        endcase
    endtask

    // Drop valid, wait for every outcome, then let the pipeline empty
    task automatic settle();
        s_valid <= 1'b0;
        while (due_outcomes.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Offer one byte and hold it until accepted; leaves valid high
    task automatic push_byte(input logic [7:0] b, input logic last_b,
                             output logic hit, output t_scan_outcome res);
        calm <= (items_sent >= 700 && items_sent < 1000);
        if (!calm && $urandom_range(99) < 6) begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        s_last  <= last_b;
        do @(posedge clk); while (!s_ready);
        items_sent++;
        window_scan(b, last_b, hit, res);
    endtask

    // Check each result word against the oldest outcome; stall at random
    always @(posedge clk) begin
        t_scan_outcome want;
        if (rst_n && m_valid && m_ready) begin
            if (due_outcomes.size() == 0) begin
                fail_count++;
                mismatches++;
                if (mismatches <= SHOW_MAX)
                    $display("unexpected result word: found=%0b addr=%h", m_user, m_data);
            end else begin
                want = due_outcomes.pop_front();
                if (m_user !== want.found || m_data !== want.addr) begin
                    fail_count++;
                    mismatches++;
                    if (mismatches <= SHOW_MAX)
                        $display("result mismatch: found exp %0b got %0b, addr exp %h got %h",
                                 want.found, m_user, want.addr, m_data);
                end
            end
        end
        m_ready <= calm || ($urandom_range(99) >= 6);
    end

    initial begin
        int                r;
        int                n;
        int                span;
        int                at;
        int                stop;
        int                regions;
        int                ln;
        logic              cut;
        logic              hit;
        logic [REG_W-1:0]  v;
        logic [MASK_W-1:0] m;
        logic [7:0]        region [64];
        t_scan_outcome     outc;

        clear_region();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        for (r = 0; r < DIR_N; r++) begin
            if (dir_rows[r].kind == ROW_REG) begin
                settle();
                write_reg(dir_rows[r].idx, dir_rows[r].value);
            end else begin
                push_byte(dir_rows[r].data, dir_rows[r].last, hit, outc);
                case (dir_rows[r].kind)
                    ROW_BYTE: if (hit) due_outcomes.push_back(outc);
                    ROW_HIT: begin
                        outc.found = 1'b1;
                        outc.addr  = dir_rows[r].value;
                        due_outcomes.push_back(outc);
                    end
                    ROW_MISS: begin
                        outc = '0;
                        due_outcomes.push_back(outc);
                    end
                    default: ;
                endcase
            end
        end

        // Random phases: new settings, then a few regions
        while (items_sent < TARGET_WORDS) begin
            settle();
            case ($urandom_range(3))
                0:       v = '0;
                1:       v = '1;
                2:       v = 64'hFFFF_FFFF_FFFF_FF00 | REG_W'($urandom_range(255));
                default: v = {$urandom, $urandom};
            endcase
            write_reg(CFG_BASE_ADDRESS, v);
            write_reg(CFG_PATTERN_LOW, {$urandom, $urandom});
            write_reg(CFG_PATTERN_HIGH, {$urandom, $urandom});
            case ($urandom_range(4))
                0:       m = '0;
                1:       m = '1;
                2:       m = MASK_W'($urandom & $urandom);
                default: m = MASK_W'($urandom);
            endcase
            v = {$urandom, $urandom};
            v[MASK_W-1:0] = m;
            write_reg(CFG_WILDCARD, v);
            case ($urandom_range(9))
                0:       ln = 0;
                1:       ln = $urandom_range(17, 31);
                2:       ln = MAX_PATTERN;
                3:       ln = 1;
                default: ln = $urandom_range(2, 15);
            endcase
            v = $urandom_range(1) ? {$urandom, $urandom} : '0;
            v[4:0] = 5'(ln);
            write_reg(CFG_PATTERN_LEN, v);
            if ($urandom_range(3) == 0)
                write_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI, {$urandom, $urandom});

            regions = $urandom_range(2, 6);
            for (int g = 0; g < regions; g++) begin
                n = len_used();
                case ($urandom_range(9))
                    0:       span = $urandom_range(40, 60);
                    1:       span = $urandom_range(1, n);
                    default: span = $urandom_range(n, 2 * n + 8);
                endcase
                // Noise biased toward pattern bytes so near misses happen
                for (int k = 0; k < span; k++)
                    region[k] = $urandom_range(1) ? pattern_at($urandom_range(n - 1))
                                                  : 8'($urandom);
                // Plant a full instance, sometimes with one byte broken
                if (span >= n && $urandom_range(9) < 7) begin
                    at = $urandom_range(span - n);
                    for (int k = 0; k < n; k++)
                        if (!wmask[k]) region[at+k] = pattern_at(k);
                    if ($urandom_range(3) == 0)
                        region[at + $urandom_range(n - 1)] ^= 8'($urandom_range(1, 255));
                end
                // Leave the final region open now and then so new settings hit mid-region
                cut  = (g == regions - 1) && ($urandom_range(4) == 0);
                stop = cut ? $urandom_range(1, span) : span;
                for (int k = 0; k < stop; k++) begin
                    push_byte(region[k], !cut && (k == span - 1), hit, outc);
                    if (hit) due_outcomes.push_back(outc);
                end
            end
        end

        // Drain and report
        s_valid <= 1'b0;
        while (due_outcomes.size() != 0) @(posedge clk);
        repeat (END_WAIT) @(posedge clk);
        if (fail_count == 0 && due_outcomes.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
